/* rtl/hgs_pkg.sv */
// Shared types and constants for the height-map grid sampler.
package hgs_pkg;

	localparam int MAP_DIM_MAX_DEF  = 256;
	localparam int GRID_DIM_MAX_DEF = 4096;

	localparam int GRID_W  = 13;
	localparam int MAP_W   = 9;
	localparam int COORD_W = 12;
	localparam int HGT_W   = 16;
	localparam int FRAC_W  = 16;
	localparam int IDX_W   = 24;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [1:0] {
		REG_OUT_WIDTH  = 2'd0,
		REG_OUT_HEIGHT = 2'd1,
		REG_MAP_WIDTH  = 2'd2,
		REG_MAP_HEIGHT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic               req;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [HGT_W-1:0]   hin;
		logic               load_ok;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  vidx;
		logic [FRAC_W-1:0] u;
		logic [FRAC_W-1:0] v;
		logic              cvalid;
		logic [IDX_W-1:0]  cr;
		logic [IDX_W-1:0]  cb;
		logic [IDX_W-1:0]  cd;
	} res_t;

	typedef struct packed {
		logic              i0p;
		logic              i1p;
		logic              j0p;
		logic              j1p;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
	} tap_t;

	typedef struct packed {
		res_t             res;
		logic [HGT_W-1:0] hgt;
	} out_t;

endpackage

/* rtl/hgs_frac_div.sv */
// Pipelined restoring divider: two lanes (col/width, row/height) as 16-bit fractions, one bit per stage.
module hgs_frac_div (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  hgs_pkg::item_t                          in_item,
	input  logic [1:0][hgs_pkg::COORD_W-1:0]        num,
	input  logic [1:0][hgs_pkg::GRID_W-1:0]         den,
	input  logic [1:0]                              sat,
	output logic                                    out_valid,
	output hgs_pkg::item_t                          out_item,
	output logic [1:0][hgs_pkg::FRAC_W-1:0]         frac
);

	localparam int N  = hgs_pkg::FRAC_W;
	localparam int GW = hgs_pkg::GRID_W;

	logic [N-1:0]           vld_s;
	hgs_pkg::item_t         item_s [N];
	logic [1:0][GW-1:0]     rem_s  [N];
	logic [1:0][N-1:0]      quo_s  [N];
	logic [1:0]             sat_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic               pv;
		hgs_pkg::item_t     pit;
		logic [1:0][GW-1:0] prem;
		logic [1:0][N-1:0]  pquo;
		logic [1:0]         psat;
		logic [1:0][GW-1:0] nrem;
		logic [1:0][N-1:0]  nquo;

		if (k == 0) begin : g_first
			always_comb begin
				pv   = in_valid;
				pit  = in_item;
				psat = sat;
				pquo = '0;
				for (int l = 0; l < 2; l++) begin
					prem[l] = sat[l] ? '0 : GW'(num[l]);
				end
			end
		end else begin : g_next
			always_comb begin
				pv   = vld_s[k-1];
				pit  = item_s[k-1];
				psat = sat_s[k-1];
				pquo = quo_s[k-1];
				prem = rem_s[k-1];
			end
		end

		always_comb begin
			logic [GW:0] sh;
			sh = '0;
			for (int l = 0; l < 2; l++) begin
				sh = {prem[l], 1'b0};
				if (sh >= {1'b0, den[l]}) begin
					nrem[l] = GW'(sh - {1'b0, den[l]});
					nquo[l] = {pquo[l][N-2:0], 1'b1};
				end else begin
					nrem[l] = GW'(sh);
					nquo[l] = {pquo[l][N-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_s[k] <= pit;
				rem_s[k]  <= nrem;
				quo_s[k]  <= nquo;
				sat_s[k]  <= psat;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_item  = item_s[N-1];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			frac[l] = sat_s[N-1][l] ? '1 : quo_s[N-1][l];
		end
	end

endmodule

/* rtl/hgs_height_store.sv */
// Height map in four banks split by column and row parity, one read and one write port per bank.
module hgs_height_store #(
	parameter int MAP_DIM_MAX = hgs_pkg::MAP_DIM_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic                        wr_en,
	input  logic [hgs_pkg::COORD_W-1:0] wr_col,
	input  logic [hgs_pkg::COORD_W-1:0] wr_row,
	input  logic [hgs_pkg::HGT_W-1:0]   wr_data,
	input  logic                        rd_en,
	input  logic [hgs_pkg::MAP_W-1:0]   i0,
	input  logic [hgs_pkg::MAP_W-1:0]   i1,
	input  logic [hgs_pkg::MAP_W-1:0]   j0,
	input  logic [hgs_pkg::MAP_W-1:0]   j1,
	output logic [hgs_pkg::HGT_W-1:0]   rd_data [4]
);

	localparam int AW = $clog2(MAP_DIM_MAX);
	localparam int HW = (AW > 1) ? AW - 1 : 1;
	localparam int BD = 1 << (2 * HW);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic PC = 1'(b % 2);
		localparam logic PR = 1'(b / 2);

		logic [hgs_pkg::HGT_W-1:0] mem [BD];
		logic [hgs_pkg::HGT_W-1:0] rdat_q;
		logic [hgs_pkg::MAP_W-1:0] ca;
		logic [hgs_pkg::MAP_W-1:0] ra;
		logic [AW:0]               cx;
		logic [AW:0]               rx;
		logic [AW:0]               wx;
		logic [AW:0]               wy;
		logic [2*HW-1:0]           raddr;
		logic [2*HW-1:0]           waddr;
		logic                      we;

		assign ca    = (i0[0] == PC) ? i0 : i1;
		assign ra    = (j0[0] == PR) ? j0 : j1;
		assign cx    = (AW+1)'(ca);
		assign rx    = (AW+1)'(ra);
		assign wx    = (AW+1)'(wr_col);
		assign wy    = (AW+1)'(wr_row);
		assign raddr = {rx[HW:1], cx[HW:1]};
		assign waddr = {wy[HW:1], wx[HW:1]};
		assign we    = wr_en && (wr_col[0] == PC) && (wr_row[0] == PR);

		always_ff @(posedge clk) begin
			if (en) begin
				if (we) begin
					mem[waddr] <= wr_data;
				end
				if (rd_en) begin
					rdat_q <= mem[raddr];
				end
			end
		end

		assign rd_data[b] = rdat_q;
	end

endmodule

/* rtl/hgs_interp.sv */
// Five-stage bilinear interpolation: corner select, x blend, difference, y partial products, round.
module hgs_interp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  hgs_pkg::res_t                    in_res,
	input  hgs_pkg::tap_t                    tap,
	input  logic [hgs_pkg::HGT_W-1:0]        bank [4],
	output logic                             out_valid,
	output hgs_pkg::res_t                    out_res,
	output logic [hgs_pkg::HGT_W-1:0]        height
);

	localparam int FW = hgs_pkg::FRAC_W;

	logic [4:0] vld_s;

	// stage 1
	hgs_pkg::res_t       res_s1;
	logic [FW-1:0]       fx_s1, fy_s1;
	logic [15:0]         h00_s1, h01_s1;
	logic signed [16:0]  d0_s1, d1_s1;
	logic [15:0]         h00, h10, h01, h11;

	// stage 2
	hgs_pkg::res_t       res_s2;
	logic [FW-1:0]       fy_s2;
	logic signed [33:0]  a0_s2, a1_s2;
	logic signed [33:0]  p0, p1;

	// stage 3
	hgs_pkg::res_t       res_s3;
	logic [FW-1:0]       fy_s3;
	logic signed [33:0]  base_s3;
	logic signed [34:0]  e_s3;

	// stage 4
	hgs_pkg::res_t       res_s4;
	logic signed [33:0]  base_s4;
	logic signed [34:0]  ph_s4;
	logic [32:0]         pl_s4;

	// stage 5
	hgs_pkg::res_t       res_s5;
	logic [15:0]         hgt_s5;
	logic signed [52:0]  acc;
	logic [52:0]         rnd;

	assign h00 = bank[{tap.j0p, tap.i0p}];
	assign h10 = bank[{tap.j0p, tap.i1p}];
	assign h01 = bank[{tap.j1p, tap.i0p}];
	assign h11 = bank[{tap.j1p, tap.i1p}];

	assign p0 = d0_s1 * $signed({1'b0, fx_s1});
	assign p1 = d1_s1 * $signed({1'b0, fx_s1});

	assign acc = $signed({{3{base_s4[33]}}, base_s4, 16'd0})
	           + $signed({ph_s4[34], ph_s4, 17'd0})
	           + $signed({20'd0, pl_s4});
	assign rnd = acc + (53'd1 << 31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1  <= in_res;
			fx_s1   <= tap.fx;
			fy_s1   <= tap.fy;
			h00_s1  <= h00;
			h01_s1  <= h01;
			d0_s1   <= $signed({h10[15], h10}) - $signed({h00[15], h00});
			d1_s1   <= $signed({h11[15], h11}) - $signed({h01[15], h01});

			res_s2  <= res_s1;
			fy_s2   <= fy_s1;
			a0_s2   <= $signed({{2{h00_s1[15]}}, h00_s1, 16'd0}) + p0;
			a1_s2   <= $signed({{2{h01_s1[15]}}, h01_s1, 16'd0}) + p1;

			res_s3  <= res_s2;
			fy_s3   <= fy_s2;
			base_s3 <= a0_s2;
			e_s3    <= $signed({a1_s2[33], a1_s2}) - $signed({a0_s2[33], a0_s2});

			res_s4  <= res_s3;
			base_s4 <= base_s3;
			ph_s4   <= $signed(e_s3[34:17]) * $signed({1'b0, fy_s3});
			pl_s4   <= 33'(e_s3[16:0]) * 33'(fy_s3);

			res_s5  <= res_s4;
			hgt_s5  <= rnd[47:32];
		end
	end

	assign out_valid = vld_s[4];
	assign out_res   = res_s5;
	assign height    = hgt_s5;

endmodule

/* rtl/heightmap_grid_mesh_sampler.sv */
// Top level of the height-map grid sampler: register port, front stages, store, interpolation, output buffer.
//
//  channel  | handshake             | word
//  ---------+-----------------------+--------------------------------------------------
//  req      | req_valid / req_ready | req_type, col, row, height_in
//  res      | res_valid / res_ready | vertex_index, coord_u, coord_v, height_out,
//           |                       | cell_valid, corner_right, corner_below, corner_diag
//  cfg      | psel, penable, pwrite | paddr, pwdata, prdata (pready tied high)
//
// One word per cycle while the output buffer is not full. A query passes the input register,
// the bit-per-stage divider for u and v, the scale and index stages, the banked map read and the blend.
// Loads write the map at the read stage, so later queries see them in order; loads give no word.
// Stalls: a two-word output buffer; the whole pipeline holds while it is full.
// Reset clears valid bits and the buffer count and sets config registers to 256, not the data path or map.
module heightmap_grid_mesh_sampler #(
	parameter int MAP_DIM_MAX  = hgs_pkg::MAP_DIM_MAX_DEF,
	parameter int GRID_DIM_MAX = hgs_pkg::GRID_DIM_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hgs_pkg::ADDR_W-1:0]  paddr,
	input  logic [hgs_pkg::DATA_W-1:0]  pwdata,
	output logic [hgs_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic                        req_type,
	input  logic [hgs_pkg::COORD_W-1:0] col,
	input  logic [hgs_pkg::COORD_W-1:0] row,
	input  logic signed [15:0]          height_in,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [hgs_pkg::IDX_W-1:0]   vertex_index,
	output logic [hgs_pkg::FRAC_W-1:0]  coord_u,
	output logic [hgs_pkg::FRAC_W-1:0]  coord_v,
	output logic signed [15:0]          height_out,
	output logic                        cell_valid,
	output logic [hgs_pkg::IDX_W-1:0]   corner_right,
	output logic [hgs_pkg::IDX_W-1:0]   corner_below,
	output logic [hgs_pkg::IDX_W-1:0]   corner_diag
);

	localparam int GW = hgs_pkg::GRID_W;
	localparam int MW = hgs_pkg::MAP_W;
	localparam int CW = hgs_pkg::COORD_W;
	localparam int FW = hgs_pkg::FRAC_W;
	localparam int IW = hgs_pkg::IDX_W;

	// config
	logic [GW-1:0] ow_q, oh_q;
	logic [MW-1:0] mw_q, mh_q;
	logic [GW-1:0] ow, oh;
	logic [MW-1:0] mw, mh;
	logic          cfg_wr;
	hgs_pkg::reg_idx_t ridx;

	// flow control
	logic adv;
	logic [1:0] cnt_q;
	logic wr_ptr_q, rd_ptr_q;
	hgs_pkg::out_t buf_q [2];
	logic push, pop;

	// stage 1
	logic           vld_s1;
	hgs_pkg::item_t item_s1;
	hgs_pkg::item_t item_in;

	// divider out
	logic                    dv;
	hgs_pkg::item_t          ditem;
	logic [1:0][FW-1:0]      dfrac;
	logic [1:0][CW-1:0]      dnum;
	logic [1:0][GW-1:0]      dden;
	logic [1:0]              dsat;

	// stage 2
	logic           vld_s2;
	hgs_pkg::item_t item_s2;
	logic [FW-1:0]  u_s2, v_s2;
	logic [24:0]    posx_s2, posy_s2, kprod_s2;

	// stage 3
	logic           vld_s3;
	hgs_pkg::item_t item_s3;
	logic [MW-1:0]  i0_s3, i1_s3, j0_s3, j1_s3;
	hgs_pkg::tap_t  tap_s3;
	hgs_pkg::res_t  res_s3;
	logic [MW-1:0]  i0, i1, j0, j1, xi, yj, mw1, mh1;
	hgs_pkg::res_t  res_c;
	logic [IW-1:0]  k;

	// stage 4
	logic           qv_s4;
	hgs_pkg::tap_t  tap_s4;
	hgs_pkg::res_t  res_s4;
	logic [hgs_pkg::HGT_W-1:0] bank [4];

	// interp out
	logic          iv;
	hgs_pkg::res_t ires;
	logic [15:0]   ihgt;
	hgs_pkg::out_t head;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign ridx   = hgs_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q <= GW'(256);
			oh_q <= GW'(256);
			mw_q <= MW'(256);
			mh_q <= MW'(256);
		end else if (cfg_wr) begin
			case (ridx)
				hgs_pkg::REG_OUT_WIDTH:  ow_q <= pwdata[GW-1:0];
				hgs_pkg::REG_OUT_HEIGHT: oh_q <= pwdata[GW-1:0];
				hgs_pkg::REG_MAP_WIDTH:  mw_q <= pwdata[MW-1:0];
				hgs_pkg::REG_MAP_HEIGHT: mh_q <= pwdata[MW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			hgs_pkg::REG_OUT_WIDTH:  prdata = 32'(ow_q);
			hgs_pkg::REG_OUT_HEIGHT: prdata = 32'(oh_q);
			hgs_pkg::REG_MAP_WIDTH:  prdata = 32'(mw_q);
			hgs_pkg::REG_MAP_HEIGHT: prdata = 32'(mh_q);
			default:                 prdata = '0;
		endcase
	end

	// clamped sizes
	assign ow = (ow_q < GW'(2)) ? GW'(2) : ((32'(ow_q) > GRID_DIM_MAX) ? GW'(GRID_DIM_MAX) : ow_q);
	assign oh = (oh_q < GW'(2)) ? GW'(2) : ((32'(oh_q) > GRID_DIM_MAX) ? GW'(GRID_DIM_MAX) : oh_q);
	assign mw = (mw_q == '0) ? MW'(1) : ((32'(mw_q) > MAP_DIM_MAX) ? MW'(MAP_DIM_MAX) : mw_q);
	assign mh = (mh_q == '0) ? MW'(1) : ((32'(mh_q) > MAP_DIM_MAX) ? MW'(MAP_DIM_MAX) : mh_q);

	assign adv       = !cnt_q[1];
	assign req_ready = adv;

	// stage 1: input word
	always_comb begin
		item_in.req     = req_type;
		item_in.col     = col;
		item_in.row     = row;
		item_in.hin     = height_in;
		item_in.load_ok = (col < CW'(mw)) && (row < CW'(mh));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_in;
		end
	end

	assign dnum[0] = item_s1.col;
	assign dnum[1] = item_s1.row;
	assign dden[0] = ow;
	assign dden[1] = oh;
	assign dsat[0] = {1'b0, item_s1.col} >= ow;
	assign dsat[1] = {1'b0, item_s1.row} >= oh;

	hgs_frac_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s1),
		.in_item   (item_s1),
		.num       (dnum),
		.den       (dden),
		.sat       (dsat),
		.out_valid (dv),
		.out_item  (ditem),
		.frac      (dfrac)
	);

	// stage 2: scale fractions, row product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2  <= ditem;
			u_s2     <= dfrac[0];
			v_s2     <= dfrac[1];
			posx_s2  <= 25'(dfrac[0]) * 25'(mw);
			posy_s2  <= 25'(dfrac[1]) * 25'(mh);
			kprod_s2 <= 25'(ditem.row) * 25'(ow);
		end
	end

	// stage 3: neighbor indices, weights, triangle corners
	assign mw1 = mw - MW'(1);
	assign mh1 = mh - MW'(1);
	assign xi  = posx_s2[24:16];
	assign yj  = posy_s2[24:16];
	assign i0  = (xi > mw1) ? mw1 : xi;
	assign j0  = (yj > mh1) ? mh1 : yj;
	assign i1  = ((posx_s2[15:0] != '0) && (i0 < mw1)) ? i0 + MW'(1) : i0;
	assign j1  = ((posy_s2[15:0] != '0) && (j0 < mh1)) ? j0 + MW'(1) : j0;
	assign k   = IW'(kprod_s2 + 25'(item_s2.col));

	always_comb begin
		res_c.vidx   = k;
		res_c.u      = u_s2;
		res_c.v      = v_s2;
		res_c.cvalid = (({1'b0, item_s2.col} + GW'(1)) < ow)
		            && (({1'b0, item_s2.row} + GW'(1)) < oh);
		res_c.cr     = res_c.cvalid ? IW'(k + IW'(1)) : '0;
		res_c.cb     = res_c.cvalid ? IW'(k + IW'(ow)) : '0;
		res_c.cd     = res_c.cvalid ? IW'(k + IW'(ow) + IW'(1)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s3    <= item_s2;
			i0_s3      <= i0;
			i1_s3      <= i1;
			j0_s3      <= j0;
			j1_s3      <= j1;
			tap_s3.i0p <= i0[0];
			tap_s3.i1p <= i1[0];
			tap_s3.j0p <= j0[0];
			tap_s3.j1p <= j1[0];
			tap_s3.fx  <= posx_s2[15:0];
			tap_s3.fy  <= posy_s2[15:0];
			res_s3     <= res_c;
		end
	end

	// stage 4: map access
	hgs_height_store #(
		.MAP_DIM_MAX (MAP_DIM_MAX)
	) u_store (
		.clk     (clk),
		.en      (adv),
		.wr_en   (vld_s3 && (item_s3.req == hgs_pkg::REQ_LOAD) && item_s3.load_ok),
		.wr_col  (item_s3.col),
		.wr_row  (item_s3.row),
		.wr_data (item_s3.hin),
		.rd_en   (vld_s3 && (item_s3.req == hgs_pkg::REQ_QUERY)),
		.i0      (i0_s3),
		.i1      (i1_s3),
		.j0      (j0_s3),
		.j1      (j1_s3),
		.rd_data (bank)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s4 <= 1'b0;
		end else if (adv) begin
			qv_s4 <= vld_s3 && (item_s3.req == hgs_pkg::REQ_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tap_s4 <= tap_s3;
			res_s4 <= res_s3;
		end
	end

	hgs_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (qv_s4),
		.in_res    (res_s4),
		.tap       (tap_s4),
		.bank      (bank),
		.out_valid (iv),
		.out_res   (ires),
		.height    (ihgt)
	);

	// output buffer
	assign push = adv && iv;
	assign pop  = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q].res <= ires;
			buf_q[wr_ptr_q].hgt <= ihgt;
		end
	end

	assign head         = buf_q[rd_ptr_q];
	assign res_valid    = (cnt_q != 2'd0);
	assign vertex_index = head.res.vidx;
	assign coord_u      = head.res.u;
	assign coord_v      = head.res.v;
	assign height_out   = head.hgt;
	assign cell_valid   = head.res.cvalid;
	assign corner_right = head.res.cr;
	assign corner_below = head.res.cb;
	assign corner_diag  = head.res.cd;

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !cnt_q[1])
		else $error("push into full output buffer");

	a_cell_not_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && cell_valid |-> coord_u != 16'hFFFF && coord_v != 16'hFFFF)
		else $error("valid cell with saturated coordinate");

	a_corner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !cell_valid |-> corner_right == '0 && corner_below == '0
			&& corner_diag == '0)
		else $error("corners set on invalid cell");

	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[1] && !pop |=> cnt_q[1])
		else $error("full buffer drained without a pop");
`endif

endmodule

/* bench/heightmap_grid_mesh_sampler_tb.sv */
// Self-checking testbench for the height-map grid sampler: directed and random loads and queries.
module heightmap_grid_mesh_sampler_tb;

	localparam int MAPN = 256;
	localparam int LIMIT = 400000;

	typedef struct {
		logic        typ;
		logic [11:0] c;
		logic [11:0] r;
		logic [15:0] h;
	} req_word_t;

	typedef struct {
		logic [23:0] vidx;
		logic [15:0] u;
		logic [15:0] v;
		logic [15:0] hgt;
		logic        cv;
		logic [23:0] cr;
		logic [23:0] cb;
		logic [23:0] cd;
	} vertex_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [hgs_pkg::ADDR_W-1:0] paddr = '0;
	logic [hgs_pkg::DATA_W-1:0] pwdata = '0;
	logic [hgs_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 0, req_ready, req_type = 0;
	logic [11:0] col = 0, row = 0;
	logic signed [15:0] height_in = 0;
	logic res_valid, res_ready = 0;
	logic [23:0] vertex_index, corner_right, corner_below, corner_diag;
	logic [15:0] coord_u, coord_v;
	logic signed [15:0] height_out;
	logic cell_valid;

	heightmap_grid_mesh_sampler u_dut (.*);

	always #1 clk = ~clk;

	logic [15:0] heights [MAPN*MAPN];
	int unsigned ow = 256, oh = 256, mw = 256, mh = 256;
	req_word_t pending [$];
	vertex_t expected_vertices [$];
	int errors = 0, n_checked = 0, n_queries = 0, n_loads = 0;
	int unsigned cycles = 0;
	int hold_off = 0;
	bit tx_pause = 0;
	int phase_w [5] = '{2, 4096, 7, 300, 13};
	int phase_h [5] = '{2, 4096, 5, 0, 9};
	int map_w [5] = '{1, 2, 5, 3, 16};
	int map_h [5] = '{1, 3, 4, 2, 12};

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	function automatic int unsigned clamp(int unsigned x, int unsigned lo, int unsigned hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic longint unsigned to_frac(longint unsigned n, longint unsigned d);
		longint unsigned q;
		if (n >= d) return 65535;
		q = (n << 16) / d;
		return q > 65535 ? 65535 : q;
	endfunction

	function automatic longint read_map(longint unsigned c, longint unsigned r);
		return longint'($signed(heights[r*MAPN + c]));
	endfunction

	function automatic vertex_t sample_vertex(logic [11:0] c, logic [11:0] r);
		vertex_t e;
		longint unsigned w, h, u, v, px, py, i0, i1, j0, j1, fx, fy, k;
		longint unsigned mwi, mhi;
		longint acc;
		w = clamp(ow, 2, 4096); h = clamp(oh, 2, 4096);
		mwi = clamp(mw, 1, MAPN); mhi = clamp(mh, 1, MAPN);
		u = to_frac(c, w); v = to_frac(r, h);
		px = u * mwi; i0 = px >> 16; fx = px & 16'hFFFF;
		if (i0 > mwi-1) i0 = mwi-1;
		i1 = i0 + (fx != 0); if (i1 > mwi-1) i1 = mwi-1;
		py = v * mhi; j0 = py >> 16; fy = py & 16'hFFFF;
		if (j0 > mhi-1) j0 = mhi-1;
		j1 = j0 + (fy != 0); if (j1 > mhi-1) j1 = mhi-1;
		acc = read_map(i0,j0) * longint'((65536-fx)*(65536-fy))
			+ read_map(i1,j0) * longint'(fx*(65536-fy))
			+ read_map(i0,j1) * longint'((65536-fx)*fy)
			+ read_map(i1,j1) * longint'(fx*fy);
		acc = ((acc + (longint'(32768) << 32) + (longint'(1) << 31)) >>> 32) - 32768;
		k = (r * w + c) & 24'hFFFFFF;
		e.vidx = k[23:0]; e.u = u[15:0]; e.v = v[15:0]; e.hgt = acc[15:0];
		e.cv = (c + 1 < w) && (r + 1 < h);
		e.cr = e.cv ? 24'(k + 1) : 24'd0;
		e.cb = e.cv ? 24'(k + w) : 24'd0;
		e.cd = e.cv ? 24'(k + w + 1) : 24'd0;
		return e;
	endfunction

	function automatic void accept_word(req_word_t it);
		int unsigned mwi, mhi;
		mwi = clamp(mw, 1, MAPN); mhi = clamp(mh, 1, MAPN);
		if (it.typ == hgs_pkg::REQ_LOAD) begin
			if (it.c < mwi && it.r < mhi) begin
				heights[it.r*MAPN + it.c] = it.h;
			end
		end else begin
			expected_vertices.push_back(sample_vertex(it.c, it.r));
		end
	endfunction

	// driver
	int tx_gap = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (req_valid && req_ready) accept_word(pending.pop_front());
		if (req_valid && !req_ready) begin
		end else if (tx_gap > 0) begin
			tx_gap <= tx_gap - 1;
			req_valid <= 0;
		end else if (!tx_pause && arst_n && pending.size() > 0) begin
			req_word_t nx;
			nx = pending[0];
			req_valid <= 1;
			req_type <= nx.typ; col <= nx.c; row <= nx.r; height_in <= nx.h;
			if (req_valid && req_ready) tx_gap <= ($urandom_range(0,3) == 0) ? $urandom_range(0,12) : 0;
		end else begin
			req_valid <= 0;
		end
	end

	// monitor
	int rx_gap = 0;
	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (expected_vertices.size() == 0) begin
				report("unexpected word", vertex_index, 0);
			end else begin
				vertex_t e;
				e = expected_vertices.pop_front();
				n_checked++;
				if (vertex_index !== e.vidx) report("vertex_index", vertex_index, e.vidx);
				if (coord_u !== e.u) report("coord_u", coord_u, e.u);
				if (coord_v !== e.v) report("coord_v", coord_v, e.v);
				if (height_out !== e.hgt) report("height_out", height_out, e.hgt);
				if (cell_valid !== e.cv) report("cell_valid", cell_valid, e.cv);
				if (corner_right !== e.cr) report("corner_right", corner_right, e.cr);
				if (corner_below !== e.cb) report("corner_below", corner_below, e.cb);
				if (corner_diag !== e.cd) report("corner_diag", corner_diag, e.cd);
			end
		end
		if (hold_off > 0) begin
			res_ready <= 0;
		end else if (res_ready && res_valid) begin
			rx_gap = ($urandom_range(0,3) == 0) ? $urandom_range(0,12) : 0;
			res_ready <= (rx_gap == 0);
		end else if (!res_ready) begin
			if (rx_gap > 0) rx_gap--;
			res_ready <= (rx_gap == 0);
		end
	end

	always @(posedge clk) if (hold_off > 0) hold_off <= hold_off - 1;

	always @(posedge clk) if (cycles > LIMIT) begin
		$display("timeout after %0d cycles", cycles);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic reg_write(input hgs_pkg::reg_idx_t idx, input int unsigned val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			hgs_pkg::REG_OUT_WIDTH: ow = val & 13'h1FFF;
			hgs_pkg::REG_OUT_HEIGHT: oh = val & 13'h1FFF;
			hgs_pkg::REG_MAP_WIDTH: mw = val & 9'h1FF;
			default: mh = val & 9'h1FF;
		endcase
	endtask

	task automatic drain();
		wait (pending.size() == 0 && !req_valid);
		wait (expected_vertices.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_dims(int unsigned a, int unsigned b, int unsigned c, int unsigned d);
		reg_write(hgs_pkg::REG_OUT_WIDTH, a); reg_write(hgs_pkg::REG_OUT_HEIGHT, b);
		reg_write(hgs_pkg::REG_MAP_WIDTH, c); reg_write(hgs_pkg::REG_MAP_HEIGHT, d);
	endtask

	function automatic void add(logic t, int c, int r, int h);
		req_word_t it;
		it.typ = t; it.c = 12'(c); it.r = 12'(r); it.h = 16'(h);
		pending.push_back(it);
		if (t == hgs_pkg::REQ_QUERY) n_queries++; else n_loads++;
	endfunction

	// fill the whole active map in row order, with random content
	function automatic void load_map(int unsigned w, int unsigned h);
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++)
				add(hgs_pkg::REQ_LOAD, c, r, ($urandom_range(0,5) == 0) ?
					($urandom_range(0,1) ? 16'h7FFF : 16'h8000) : $urandom);
	endfunction

	function automatic void rand_queries(int n);
		for (int i = 0; i < n; i++) begin
			int c, r;
			c = ($urandom_range(0,9) == 0) ? $urandom_range(0,4095) : $urandom_range(0, ow);
			r = ($urandom_range(0,9) == 0) ? $urandom_range(0,4095) : $urandom_range(0, oh);
			if ($urandom_range(0,7) == 0) begin
				add(hgs_pkg::REQ_LOAD, $urandom_range(0,4095), $urandom_range(0,4095), $urandom);
			end else begin
				add(hgs_pkg::REQ_QUERY, c, r, $urandom);
			end
		end
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		// directed: 2x2 dims, corner and extreme samples
		set_dims(2, 2, 2, 2);
		add(hgs_pkg::REQ_LOAD, 0, 0, 16'h7FFF); add(hgs_pkg::REQ_LOAD, 1, 0, 16'h8000);
		add(hgs_pkg::REQ_LOAD, 0, 1, 16'h8000); add(hgs_pkg::REQ_LOAD, 1, 1, 16'h7FFF);
		add(hgs_pkg::REQ_LOAD, 2, 0, 1); add(hgs_pkg::REQ_LOAD, 4095, 4095, 1);
		add(hgs_pkg::REQ_QUERY, 0, 0, 0); add(hgs_pkg::REQ_QUERY, 1, 0, 0);
		add(hgs_pkg::REQ_QUERY, 0, 1, 0);
		add(hgs_pkg::REQ_QUERY, 1, 1, 0); add(hgs_pkg::REQ_QUERY, 4095, 4095, 16'hFFFF);
		add(hgs_pkg::REQ_QUERY, 2, 0, 0); add(hgs_pkg::REQ_QUERY, 0, 2048, 0);
		drain();
		// pressure: receiver stalls long while sender keeps offering
		hold_off = 200;
		rand_queries(40);
		drain();
		for (int p = 0; p < 5; p++) begin
			set_dims(phase_w[p], phase_h[p], map_w[p], map_h[p]);
			load_map(clamp(mw,1,MAPN), clamp(mh,1,MAPN));
			rand_queries(40);
			if (p == 2) begin
				drain();
				tx_pause = 1;
				wait (expected_vertices.size() == 0);
				tx_pause = 0;
			end
			if (p == 3) begin
				add(hgs_pkg::REQ_QUERY, 4095, 0, 0); add(hgs_pkg::REQ_QUERY, 0, 4095, 0);
				add(hgs_pkg::REQ_QUERY, 2, 1, 0);
			end
			drain();
		end
		// registers out of range: 0 and large widths clamp
		set_dims(0, 8191, 0, 511);
		load_map(1, MAPN);
		rand_queries(60);
		drain();
		$display("covered %0d queries (%0d checked) and %0d loads over 7 register settings",
			n_queries, n_checked, n_loads);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

/* sim.f */
rtl/hgs_pkg.sv
rtl/hgs_frac_div.sv
rtl/hgs_height_store.sv
rtl/hgs_interp.sv
rtl/heightmap_grid_mesh_sampler.sv
bench/heightmap_grid_mesh_sampler_tb.sv
